// ===== src/sqc_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment quad clipper package
// Shared types, constants and geometry helpers for the clipper blocks.
// ----------------------------------------------------------------------------
package sqc_pkg;

    localparam int COORD_W         = 20;
    localparam int DIFF_W          = COORD_W + 1;
    localparam int CROSS_W         = 2 * DIFF_W + 1;
    localparam int NUM_W           = 64;
    localparam int COORD_FRAC_DEF  = 4;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int COORD_MAX       = 524287;
    localparam int COORD_MIN       = -524288;
    localparam int CFG_ADDR_W      = 3;

    localparam logic [1:0] MODE_NONE    = 2'd0;
    localparam logic [1:0] MODE_START   = 2'd1;
    localparam logic [1:0] MODE_END     = 2'd2;
    localparam logic [1:0] MODE_END_ALT = 2'd3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [CROSS_W-1:0] cross_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    typedef struct packed {
        coord_t     start_x;
        coord_t     start_y;
        coord_t     end_x;
        coord_t     end_y;
        logic [1:0] inside_mode;
    } seg_in_t;

    typedef struct packed {
        coord_t first_x;
        coord_t first_y;
        coord_t second_x;
        coord_t second_y;
        logic   found;
    } seg_out_t;

    typedef enum logic [1:0] {
        ORI_COL,
        ORI_CW,
        ORI_CCW
    } orient_t;

    // What the back end has to produce for one item.
    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_ONE,
        KIND_TWO
    } kind_t;

    typedef struct packed {
        point_t     seg_s;
        point_t     seg_e;
        kind_t      kind;
        logic       found;
        logic       keep_start;
        logic [1:0] edge0;
        logic [1:0] edge1;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic diff_t cdiff(input coord_t a, input coord_t b);
        diff_t r;
        r = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        return r;
    endfunction

    function automatic orient_t orient(input point_t p, input point_t q, input point_t r);
        diff_t  d0, d1, d2, d3;
        cross_t v;
        d0 = cdiff(q.y, p.y);
        d1 = cdiff(r.x, q.x);
        d2 = cdiff(q.x, p.x);
        d3 = cdiff(r.y, q.y);
        v  = d0 * d1 - d2 * d3;
        if (v == '0) return ORI_COL;
        return (v > 0) ? ORI_CW : ORI_CCW;
    endfunction

    function automatic logic on_seg(input point_t p, input point_t q, input point_t r);
        logic okx, oky;
        okx = ($signed(q.x) <= $signed(p.x) || $signed(q.x) <= $signed(r.x)) &&
              ($signed(q.x) >= $signed(p.x) || $signed(q.x) >= $signed(r.x));
        oky = ($signed(q.y) <= $signed(p.y) || $signed(q.y) <= $signed(r.y)) &&
              ($signed(q.y) >= $signed(p.y) || $signed(q.y) >= $signed(r.y));
        return okx && oky;
    endfunction

    function automatic logic touches(input point_t a0, input point_t a1,
                                     input point_t b0, input point_t b1);
        orient_t o1, o2, o3, o4;
        o1 = orient(a0, a1, b0);
        o2 = orient(a0, a1, b1);
        o3 = orient(b0, b1, a0);
        o4 = orient(b0, b1, a1);
        if (o1 != o2 && o3 != o4) return 1'b1;
        if (o1 == ORI_COL && on_seg(a0, b0, a1)) return 1'b1;
        if (o2 == ORI_COL && on_seg(a0, b1, a1)) return 1'b1;
        if (o3 == ORI_COL && on_seg(b0, a0, b1)) return 1'b1;
        if (o4 == ORI_COL && on_seg(b0, a1, b1)) return 1'b1;
        return 1'b0;
    endfunction

    function automatic cross_t det_of(input point_t s, input point_t e,
                                      input point_t q0, input point_t q1);
        diff_t ea, eb, fa, fb;
        ea = cdiff(e.y, s.y);
        eb = cdiff(s.x, e.x);
        fa = cdiff(q1.y, q0.y);
        fb = cdiff(q0.x, q1.x);
        return ea * fb - fa * eb;
    endfunction

endpackage

// ===== src/sqc_front.sv =====
// ----------------------------------------------------------------------------
// Segment quad clipper front end
// Holds the corner registers and classifies each segment against the four
// sides, picking the edges whose intersection points the back end solves.
// ----------------------------------------------------------------------------
module sqc_front
    import sqc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wen,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [COORD_W-1:0]    cfg_wdata,
    input  seg_in_t               seg_in,
    output job_t                  job,
    output point_t [3:0]          corners
);

    point_t corner_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                corner_reg[i] <= '0;
            end
        end else if (cfg_wen) begin
            if (cfg_addr[0]) begin
                corner_reg[cfg_addr[2:1]].y <= cfg_wdata;
            end else begin
                corner_reg[cfg_addr[2:1]].x <= cfg_wdata;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            corners[i] = corner_reg[i];
        end
    end

    logic [3:0] hit;
    logic [3:0] nz;
    point_t     s_pt, e_pt;

    assign s_pt = '{x: seg_in.start_x, y: seg_in.start_y};
    assign e_pt = '{x: seg_in.end_x,   y: seg_in.end_y};

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            hit[i] = touches(s_pt, e_pt, corner_reg[i], corner_reg[(i + 1) % 4]);
            nz[i]  = det_of(s_pt, e_pt, corner_reg[i], corner_reg[(i + 1) % 4]) != '0;
        end
    end

    always_comb begin
        logic [1:0] first;
        logic       any;
        logic [1:0] cnt;
        job.seg_s      = s_pt;
        job.seg_e      = e_pt;
        job.kind       = KIND_PASS;
        job.found      = 1'b0;
        job.keep_start = (seg_in.inside_mode == MODE_START);
        job.edge0      = '0;
        job.edge1      = '0;
        first          = '0;
        any            = 1'b0;
        cnt            = '0;
        if (seg_in.inside_mode != MODE_NONE) begin
            // The lowest touching edge wins.
            for (int i = 3; i >= 0; i--) begin
                if (hit[i]) begin
                    first = 2'(i);
                    any   = 1'b1;
                end
            end
            if (any) begin
                job.found = 1'b1;
                job.edge0 = first;
                // A parallel edge leaves the segment unchanged.
                job.kind  = nz[first] ? KIND_ONE : KIND_PASS;
            end
        end else begin
            for (int i = 0; i < 4; i++) begin
                if (hit[i] && nz[i]) begin
                    if (cnt == 2'd0) begin
                        job.edge0 = 2'(i);
                    end else if (cnt == 2'd1) begin
                        job.edge1 = 2'(i);
                    end
                    if (cnt != 2'd2) begin
                        cnt = cnt + 2'd1;
                    end
                end
            end
            if (cnt == 2'd2) begin
                job.kind  = KIND_TWO;
                job.found = 1'b1;
            end
        end
    end

endmodule

// ===== src/sqc_fifo.sv =====
// ----------------------------------------------------------------------------
// Segment quad clipper job queue
// Small register queue that decouples the classifier from the solver.
// ----------------------------------------------------------------------------
module sqc_fifo
    import sqc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  job_t      wr_data,
    input  logic      pop,
    output job_t      rd_data,
    output q_status_t status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t            mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg, count_next;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem[rd_ptr_reg];

    always_comb begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            if (pop)  rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            count_reg <= count_next;
        end
    end

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

// ===== src/sqc_div.sv =====
// ----------------------------------------------------------------------------
// Segment quad clipper divider
// Pipelined restoring divider, one quotient bit per stage, truncating
// toward zero. The quotient magnitude must fit in QB bits.
// ----------------------------------------------------------------------------
module sqc_div #(
    parameter int NW = 64,
    parameter int DW = 47,
    parameter int QB = 17
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [NW-1:0] num,
    input  logic signed [DW-1:0] den,
    output logic signed [QB:0]   quo
);

    logic [NW-1:0] rem_reg [QB+1];
    logic [NW-1:0] dvs_reg [QB+1];
    logic [QB-1:0] q_reg   [QB+1];
    logic          neg_reg [QB+1];
    logic [DW-1:0] den_mag;

    // The magnitude is formed at the divisor's own width before it is widened.
    assign den_mag = den[DW-1] ? DW'(-den) : DW'(den);

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num[NW-1] ? (~num + 1'b1) : num;
            dvs_reg[0] <= NW'(den_mag);
            q_reg[0]   <= '0;
            neg_reg[0] <= num[NW-1] ^ den[DW-1];
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_stage
        localparam int SH = QB - 1 - k;
        logic [NW-1:0] shd;
        logic          ge;

        assign shd = dvs_reg[k] << SH;
        assign ge  = rem_reg[k] >= shd;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= ge ? rem_reg[k] - shd : rem_reg[k];
                q_reg[k+1]   <= q_reg[k] | (ge ? (QB'(1) << SH) : '0);
                dvs_reg[k+1] <= dvs_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    assign quo = neg_reg[QB] ? -$signed({1'b0, q_reg[QB]}) : $signed({1'b0, q_reg[QB]});

endmodule

// ===== src/sqc_back.sv =====
// ----------------------------------------------------------------------------
// Segment quad clipper back end
// Solves the intersection points of the chosen edges by determinant
// division and assembles the result item in the output register.
// ----------------------------------------------------------------------------
module sqc_back
    import sqc_pkg::*;
#(
    parameter int FRAC = COORD_FRAC_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  point_t [3:0] corners,
    input  job_t         q_head,
    input  q_status_t    q_status,
    output logic         q_pop,
    output logic         m_valid,
    input  logic         m_ready,
    output seg_out_t     m_data
);

    localparam int QB  = COORD_W + 1 - FRAC;
    localparam int DW  = CROSS_W + FRAC;
    localparam int SW  = QB + FRAC + 1;
    localparam int LAT = QB + 3;
    localparam int EC_W = 2 * COORD_W + 2;

    localparam logic signed [SW-1:0] SAT_HI = SW'(COORD_MAX);
    localparam logic signed [SW-1:0] SAT_LO = SW'(COORD_MIN);

    typedef struct packed {
        point_t seg_s;
        point_t seg_e;
        kind_t  kind;
        logic   found;
        logic   keep_start;
    } tag_t;

    logic     en;
    logic     m_valid_reg;
    seg_out_t m_data_reg;

    assign en    = !m_valid_reg || m_ready;
    assign q_pop = en && !q_status.empty;

    // Stage 0: line coefficients and determinants.
    point_t                 q0 [2];
    point_t                 q1 [2];
    diff_t                  ea_c, eb_c;
    logic signed [EC_W-1:0] ec_c;
    diff_t                  fa_c [2];
    diff_t                  fb_c [2];
    logic signed [EC_W-1:0] fc_c [2];
    cross_t                 det_c [2];

    assign q0[0] = corners[q_head.edge0];
    assign q1[0] = corners[q_head.edge0 + 2'd1];
    assign q0[1] = corners[q_head.edge1];
    assign q1[1] = corners[q_head.edge1 + 2'd1];

    always_comb begin
        ea_c = cdiff(q_head.seg_e.y, q_head.seg_s.y);
        eb_c = cdiff(q_head.seg_s.x, q_head.seg_e.x);
        ec_c = ea_c * $signed(q_head.seg_s.x) + eb_c * $signed(q_head.seg_s.y);
        for (int j = 0; j < 2; j++) begin
            fa_c[j]  = cdiff(q1[j].y, q0[j].y);
            fb_c[j]  = cdiff(q0[j].x, q1[j].x);
            fc_c[j]  = fa_c[j] * $signed(q0[j].x) + fb_c[j] * $signed(q0[j].y);
            det_c[j] = ea_c * fb_c[j] - fa_c[j] * eb_c;
        end
    end

    diff_t                  b0_ea_reg, b0_eb_reg;
    logic signed [EC_W-1:0] b0_ec_reg;
    diff_t                  b0_fa_reg [2];
    diff_t                  b0_fb_reg [2];
    logic signed [EC_W-1:0] b0_fc_reg [2];
    cross_t                 b0_det_reg [2];

    always_ff @(posedge aclk) begin
        if (en) begin
            b0_ea_reg <= ea_c;
            b0_eb_reg <= eb_c;
            b0_ec_reg <= ec_c;
            for (int j = 0; j < 2; j++) begin
                b0_fa_reg[j]  <= fa_c[j];
                b0_fb_reg[j]  <= fb_c[j];
                b0_fc_reg[j]  <= fc_c[j];
                b0_det_reg[j] <= det_c[j];
            end
        end
    end

    // Stage 1: numerators, and the divisor scaled to whole pixels.
    logic signed [NUM_W-1:0] b1_numx_reg [2];
    logic signed [NUM_W-1:0] b1_numy_reg [2];
    logic signed [DW-1:0]    b1_den_reg  [2];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 2; j++) begin
                b1_numx_reg[j] <= b0_fb_reg[j] * b0_ec_reg - b0_eb_reg * b0_fc_reg[j];
                b1_numy_reg[j] <= b0_ea_reg * b0_fc_reg[j] - b0_fa_reg[j] * b0_ec_reg;
                b1_den_reg[j]  <= DW'(b0_det_reg[j]) <<< FRAC;
            end
        end
    end

    logic signed [QB:0] qx [2];
    logic signed [QB:0] qy [2];

    for (genvar j = 0; j < 2; j++) begin : g_pt
        sqc_div #(.NW(NUM_W), .DW(DW), .QB(QB)) u_div_x (
            .aclk (aclk),
            .en   (en),
            .num  (b1_numx_reg[j]),
            .den  (b1_den_reg[j]),
            .quo  (qx[j])
        );
        sqc_div #(.NW(NUM_W), .DW(DW), .QB(QB)) u_div_y (
            .aclk (aclk),
            .en   (en),
            .num  (b1_numy_reg[j]),
            .den  (b1_den_reg[j]),
            .quo  (qy[j])
        );
    end

    // Item bookkeeping that travels alongside the arithmetic.
    tag_t tag_reg   [LAT];
    logic valid_reg [LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= q_pop;
            for (int i = 1; i < LAT; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg[0] <= '{seg_s: q_head.seg_s, seg_e: q_head.seg_e, kind: q_head.kind,
                            found: q_head.found, keep_start: q_head.keep_start};
            for (int i = 1; i < LAT; i++) begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    function automatic coord_t to_coord(input logic signed [QB:0] q);
        logic signed [SW-1:0] v;
        v = SW'(q) <<< FRAC;
        if (v > SAT_HI) return coord_t'(SAT_HI);
        if (v < SAT_LO) return coord_t'(SAT_LO);
        return coord_t'(v);
    endfunction

    point_t   p0, p1, keep_pt;
    tag_t     tl;
    seg_out_t res;

    assign tl      = tag_reg[LAT-1];
    assign p0      = '{x: to_coord(qx[0]), y: to_coord(qy[0])};
    assign p1      = '{x: to_coord(qx[1]), y: to_coord(qy[1])};
    assign keep_pt = tl.keep_start ? tl.seg_s : tl.seg_e;

    always_comb begin
        case (tl.kind)
            KIND_ONE: res = '{first_x: p0.x, first_y: p0.y,
                              second_x: keep_pt.x, second_y: keep_pt.y, found: 1'b1};
            KIND_TWO: res = '{first_x: p0.x, first_y: p0.y,
                              second_x: p1.x, second_y: p1.y, found: 1'b1};
            default:  res = '{first_x: tl.seg_s.x, first_y: tl.seg_s.y,
                              second_x: tl.seg_e.x, second_y: tl.seg_e.y,
                              found: tl.found};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= valid_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/segment_quad_clipper.sv =====
// ----------------------------------------------------------------------------
// Segment quad clipper
// Clips a line segment against a configured quadrilateral cell.
// ----------------------------------------------------------------------------
// Usage:
// Load the four corners (x then y for corners 0..3, indexes 0..7) through the
// cfg write port while the block is idle; reset clears them to zero.
// Segments enter on the s_ channel and one result item per segment leaves on
// the m_ channel, in order. Both channels use valid/ready.
// The classifier tests all four sides in the accept cycle and queues a job;
// the solver pipeline computes the two candidate intersection points with
// pipelined restoring dividers, one quotient bit per stage.
// Throughput: one item per cycle while the receiver does not stall.
// From accept to m_valid an item passes the queue, the stage 0 and stage 1
// registers, the divider stages and the output register.
// When the receiver stalls, the output register holds and the solver pipeline
// freezes; the queue keeps taking items until it is full, then s_ready drops.
// After reset the queue and pipeline are empty and s_ready is high.
// ----------------------------------------------------------------------------
module segment_quad_clipper
    import sqc_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  seg_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output seg_out_t              m_data,
    input  logic                  cfg_wen,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [COORD_W-1:0]    cfg_wdata
);

    job_t         job_in, job_head;
    point_t [3:0] corners;
    q_status_t    q_status;
    logic         q_pop;

    sqc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .seg_in    (s_data),
        .job       (job_in),
        .corners   (corners)
    );

    sqc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (s_valid && s_ready),
        .wr_data (job_in),
        .pop     (q_pop),
        .rd_data (job_head),
        .status  (q_status)
    );

    sqc_back #(.FRAC(COORD_FRAC_BITS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .corners  (corners),
        .q_head   (job_head),
        .q_status (q_status),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    assign s_ready = !q_status.full;

endmodule

// ===== src/sqc_checker.sv =====
// ----------------------------------------------------------------------------
// Segment quad clipper checker
// Port-level assertions for the clipper, bound to the top level.
// ----------------------------------------------------------------------------
module sqc_checker
    import sqc_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input seg_out_t m_data
);

    // Reset empties the pipeline and the queue.
    a_reset_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    a_reset_in: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("s_ready low after reset");

    // A stalled result must hold.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

endmodule

bind segment_quad_clipper sqc_checker u_sqc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
